@@ rtl/aprm_pkg.sv @@
`timescale 1ns / 1ps
package aprm_pkg;

    localparam int LP_MAX_WINDOW  = 65536;
    localparam int LP_SAMPLE_BITS = 16;

    // fixed port and state widths
    localparam int LP_SAMPLE_W = 16;
    localparam int LP_LEVEL_W  = 16;
    localparam int LP_LEN_W    = 17;
    localparam int LP_SUM_W    = 47;
    // wide enough for the largest supported window
    localparam int LP_CNT_W    = 21;

    // window results waiting for the divide and root
    localparam int LP_Q_DEPTH = 4;
    localparam int LP_QPTR_W  = $clog2(LP_Q_DEPTH);
    localparam int LP_QLVL_W  = $clog2(LP_Q_DEPTH + 1);

    // square root operates on the quotient padded to an even width
    localparam int LP_SQV_W  = LP_SUM_W + 1;
    localparam int LP_ROOT_W = LP_SQV_W / 2;
    localparam int LP_SREM_W = LP_ROOT_W + 4;
    localparam int LP_STEP_W = $clog2(LP_SUM_W);

    typedef struct packed {
        logic [LP_LEVEL_W-1:0] peak;
        logic [LP_CNT_W-1:0]   count;
        logic                  ovf;
        logic [LP_SUM_W-1:0]   sum;
    } t_window;

endpackage

@@ rtl/aprm_in_if.sv @@
`timescale 1ns / 1ps
interface aprm_in_if
    import aprm_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [LP_SAMPLE_W-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

@@ rtl/aprm_out_if.sv @@
`timescale 1ns / 1ps
interface aprm_out_if
    import aprm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [LP_LEVEL_W-1:0] peak_level;
    logic [LP_LEVEL_W-1:0] rms_level;
    logic [LP_LEN_W-1:0]   window_length;
    logic                  overflowed;

    modport source (output valid, output peak_level, output rms_level,
                    output window_length, output overflowed, input ready);
    modport sink (input valid, input peak_level, input rms_level,
                  input window_length, input overflowed, output ready);
endinterface

@@ rtl/aprm_front.sv @@
`timescale 1ns / 1ps
module aprm_front
    import aprm_pkg::*;
#(
    parameter int MAX_WINDOW  = LP_MAX_WINDOW,
    parameter int SAMPLE_BITS = LP_SAMPLE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    aprm_in_if.sink              i_smp,
    input  logic [LP_QLVL_W-1:0] i_q_level,
    output logic                 o_push,
    output t_window              o_win
);

    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int SQ_W = 2 * SAMPLE_BITS;

    logic [SAMPLE_BITS+LP_SAMPLE_W-1:0] w_ext;
    logic [SAMPLE_BITS-1:0]             w_raw;
    logic [SAMPLE_BITS-1:0]             w_mag;
    logic                               w_room;
    logic                               w_fire;
    logic [LP_QLVL_W-1:0]               w_pend;

    logic [SAMPLE_BITS-1:0] r_peak, n_peak;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_ovf, n_ovf;
    logic [LP_SUM_W-1:0]    r_sum;

    logic                   r_p1_vld, r_p1_last, r_p1_ovf;
    logic [SAMPLE_BITS-1:0] r_p1_mag;
    logic [LP_LEVEL_W-1:0]  r_p1_peak;
    logic [LP_CNT_W-1:0]    r_p1_cnt;

    logic                   r_p2_vld, r_p2_last, r_p2_ovf;
    logic [SQ_W-1:0]        r_p2_sq;
    logic [LP_LEVEL_W-1:0]  r_p2_peak;
    logic [LP_CNT_W-1:0]    r_p2_cnt;

    logic [LP_SUM_W:0]      w_sum_ext;
    logic [LP_SUM_W-1:0]    w_sum_sat;

    // only the low sample bits count, sign taken from the top one of them
    assign w_ext = {{SAMPLE_BITS{1'b0}}, i_smp.sample};
    assign w_raw = w_ext[SAMPLE_BITS-1:0];
    assign w_mag = w_raw[SAMPLE_BITS-1]
                 ? (~w_raw + {{(SAMPLE_BITS-1){1'b0}}, 1'b1}) : w_raw;
    assign w_room = r_cnt < CW'(MAX_WINDOW);

    assign n_peak = (w_room && (w_mag > r_peak)) ? w_mag : r_peak;
    assign n_cnt  = w_room ? (r_cnt + CW'(1)) : r_cnt;
    assign n_ovf  = r_ovf | ~w_room;

    // hold off while the queue could not take every window close in flight
    assign w_pend = i_q_level + LP_QLVL_W'(r_p1_vld & r_p1_last)
                  + LP_QLVL_W'(r_p2_vld & r_p2_last);
    assign i_smp.ready = w_pend < LP_QLVL_W'(LP_Q_DEPTH);
    assign w_fire = i_smp.valid & i_smp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak   <= '0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= w_fire;
            if (w_fire) begin
                if (i_smp.last) begin
                    r_peak <= '0;
                    r_cnt  <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_peak <= n_peak;
                    r_cnt  <= n_cnt;
                    r_ovf  <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            // an ignored sample adds nothing to the sum
            r_p1_mag  <= w_room ? w_mag : '0;
            r_p1_last <= i_smp.last;
            r_p1_peak <= LP_LEVEL_W'(n_peak);
            r_p1_cnt  <= LP_CNT_W'(n_cnt);
            r_p1_ovf  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_vld) begin
            r_p2_sq   <= SQ_W'(r_p1_mag) * SQ_W'(r_p1_mag);
            r_p2_last <= r_p1_last;
            r_p2_peak <= r_p1_peak;
            r_p2_cnt  <= r_p1_cnt;
            r_p2_ovf  <= r_p1_ovf;
        end
    end

    assign w_sum_ext = {1'b0, r_sum} + (LP_SUM_W + 1)'(r_p2_sq);
    assign w_sum_sat = w_sum_ext[LP_SUM_W] ? {LP_SUM_W{1'b1}} : w_sum_ext[LP_SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_p2_vld) begin
            r_sum <= r_p2_last ? '0 : w_sum_sat;
        end
    end

    assign o_push      = r_p2_vld & r_p2_last;
    assign o_win.peak  = r_p2_peak;
    assign o_win.count = r_p2_cnt;
    assign o_win.ovf   = r_p2_ovf;
    assign o_win.sum   = w_sum_sat;

endmodule

@@ rtl/aprm_queue.sv @@
`timescale 1ns / 1ps
module aprm_queue
    import aprm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_window              i_data,
    input  logic                 i_pop,
    output t_window              o_data,
    output logic [LP_QLVL_W-1:0] o_level
);

    t_window              r_mem [LP_Q_DEPTH];
    logic [LP_QPTR_W-1:0] r_wr, r_rd;
    logic [LP_QLVL_W-1:0] r_level;
    logic                 w_pop;

    assign w_pop = i_pop & (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + LP_QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + LP_QPTR_W'(1);
            end
            r_level <= r_level + LP_QLVL_W'(i_push) - LP_QLVL_W'(w_pop);
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_level = r_level;

endmodule

@@ rtl/aprm_back.sv @@
`timescale 1ns / 1ps
module aprm_back
    import aprm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_vld,
    input  t_window i_q_data,
    output logic    o_pop,
    aprm_out_if.source o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]            r_state;
    logic [LP_STEP_W-1:0]  r_step;

    logic [LP_LEVEL_W-1:0] r_peak;
    logic [LP_LEN_W-1:0]   r_len;
    logic                  r_ovf;

    // restoring divider: quotient bits shift in as dividend bits shift out
    logic [LP_SUM_W-1:0]   r_quo;
    logic [LP_CNT_W-1:0]   r_rem;
    logic [LP_CNT_W-1:0]   r_dvs;
    logic [LP_CNT_W:0]     w_dtrial;
    logic                  w_dge;
    logic [LP_SUM_W-1:0]   n_quo;
    logic [LP_CNT_W-1:0]   n_rem;

    // square root, one result bit per step
    logic [LP_SQV_W-1:0]   r_sv;
    logic [LP_SREM_W-1:0]  r_srem;
    logic [LP_ROOT_W-1:0]  r_root;
    logic [LP_SREM_W-1:0]  w_srem_sh;
    logic [LP_SREM_W-1:0]  w_strial;
    logic                  w_sge;

    logic                  r_o_vld;
    logic [LP_LEVEL_W-1:0] r_o_peak;
    logic [LP_LEVEL_W-1:0] r_o_rms;
    logic [LP_LEN_W-1:0]   r_o_len;
    logic                  r_o_ovf;
    logic                  w_o_free;
    logic                  w_load;

    assign w_dtrial = {r_rem, r_quo[LP_SUM_W-1]};
    assign w_dge    = w_dtrial >= {1'b0, r_dvs};
    assign n_rem    = w_dge ? LP_CNT_W'(w_dtrial - {1'b0, r_dvs})
                            : w_dtrial[LP_CNT_W-1:0];
    assign n_quo    = {r_quo[LP_SUM_W-2:0], w_dge};

    assign w_srem_sh = {r_srem[LP_SREM_W-3:0], r_sv[LP_SQV_W-1:LP_SQV_W-2]};
    assign w_strial  = LP_SREM_W'({r_root, 2'b01});
    assign w_sge     = w_srem_sh >= w_strial;

    assign w_o_free = ~r_o_vld | o_res.ready;
    assign w_load   = (r_state == ST_HOLD) & w_o_free;
    assign o_pop    = (r_state == ST_IDLE) & i_q_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_q_vld) begin
                        r_state <= ST_DIV;
                        r_step  <= LP_STEP_W'(LP_SUM_W - 1);
                    end
                end
                ST_DIV: begin
                    if (r_step == '0) begin
                        r_state <= ST_SQRT;
                        r_step  <= LP_STEP_W'(LP_ROOT_W - 1);
                    end else begin
                        r_step <= r_step - LP_STEP_W'(1);
                    end
                end
                ST_SQRT: begin
                    if (r_step == '0) begin
                        r_state <= ST_HOLD;
                    end else begin
                        r_step <= r_step - LP_STEP_W'(1);
                    end
                end
                ST_HOLD: begin
                    if (w_o_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_q_vld) begin
                    r_quo  <= i_q_data.sum;
                    r_rem  <= '0;
                    r_dvs  <= i_q_data.count;
                    r_peak <= i_q_data.peak;
                    r_len  <= i_q_data.count[LP_LEN_W-1:0];
                    r_ovf  <= i_q_data.ovf;
                end
            end
            ST_DIV: begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                if (r_step == '0) begin
                    // an empty window gives a zero mean
                    r_sv   <= (r_dvs == '0) ? '0 : LP_SQV_W'(n_quo);
                    r_srem <= '0;
                    r_root <= '0;
                end
            end
            ST_SQRT: begin
                r_sv   <= {r_sv[LP_SQV_W-3:0], 2'b00};
                r_srem <= w_sge ? (w_srem_sh - w_strial) : w_srem_sh;
                r_root <= {r_root[LP_ROOT_W-2:0], w_sge};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_load) begin
            r_o_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_peak <= r_peak;
            r_o_rms  <= r_root[LP_LEVEL_W-1:0];
            r_o_len  <= r_len;
            r_o_ovf  <= r_ovf;
        end
    end

    assign o_res.valid         = r_o_vld;
    assign o_res.peak_level    = r_o_peak;
    assign o_res.rms_level     = r_o_rms;
    assign o_res.window_length = r_o_len;
    assign o_res.overflowed    = r_o_ovf;

endmodule

@@ rtl/audio_peak_rms_meter_core.sv @@
`timescale 1ns / 1ps
// Peak and RMS level meter.
// i_smp carries one signed sample per request, with last set on the final
// sample of a measurement window. Samples are taken one per cycle while the
// result queue has room for every window close still in the pipeline.
// o_res carries one request per window: peak magnitude, truncated RMS
// magnitude, the number of samples counted and a flag that is set when
// samples past MAX_WINDOW were dropped from the window.
// Accumulation runs in a three-stage front pipeline (magnitude, square,
// sum); the closing window goes into a four-entry queue. The back part
// then runs a restoring divide of the sum by the count, one quotient bit a
// cycle, and an integer square root, one root bit a cycle. It takes a new
// window from the queue only once it is back in idle, so short windows are
// limited by the back part once the queue is full, longer ones are taken at
// one sample per cycle.
// A synchronous active-low reset clears the window state, the queue and the
// output register. When the receiver stalls, the result holds in the output
// register, the back part waits, the queue fills, and then i_smp.ready drops.
module audio_peak_rms_meter_core
    import aprm_pkg::*;
#(
    parameter int MAX_WINDOW  = LP_MAX_WINDOW,
    parameter int SAMPLE_BITS = LP_SAMPLE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aprm_in_if.sink    i_smp,
    aprm_out_if.source o_res
);

    logic                 w_push;
    logic                 w_pop;
    t_window              w_push_data;
    t_window              w_head;
    logic [LP_QLVL_W-1:0] w_q_level;

    aprm_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_smp     (i_smp),
        .i_q_level (w_q_level),
        .o_push    (w_push),
        .o_win     (w_push_data)
    );

    aprm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_level (w_q_level)
    );

    aprm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_vld  (w_q_level != '0),
        .i_q_data (w_head),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );

`ifndef NO_ASSERTIONS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_q_level < LP_QLVL_W'(LP_Q_DEPTH)))
        else $error("window close pushed into a full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_q_level != '0))
        else $error("queue popped while empty");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");
`endif

endmodule
